[design/thc_pkg.sv]
package thc_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int STAMP_W   = 63;
  localparam int VAL_W     = 24;
  localparam int LIM_W     = 23;
  localparam int REQ_W     = 3;
  localparam int IDX_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [LIM_W-1:0] MAX_SPEED_RST    = LIM_W'(1310720);
  localparam logic [LIM_W-1:0] MAX_STEERING_RST = LIM_W'(27453);

  // request codes
  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LATEST = 3'd2;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INDEX  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEERING = 1'b1;

  typedef struct packed {
    logic        [STAMP_W-1:0] stamp;
    logic signed [VAL_W-1:0]   steering;
    logic signed [VAL_W-1:0]   speed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LIM_W-1:0] max_speed;
    logic [LIM_W-1:0] max_steering;
  } limits_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PUSH_CMP,
    ST_IDX_RD,
    ST_SCAN
  } state_t;

endpackage

[design/thc_mem.sv]
module thc_mem
  import thc_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = ENTRY_W,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/thc_ctrl.sv]
module thc_ctrl
  import thc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  limits_t                    limits,
  input  logic                       start,
  output logic                       busy,
  input  logic        [REQ_W-1:0]    req_type,
  input  logic        [STAMP_W-1:0]  stamp,
  input  logic        [STAMP_W-1:0]  target_stamp,
  input  logic signed [VAL_W-1:0]    steering,
  input  logic signed [VAL_W-1:0]    speed,
  input  logic        [IDX_W-1:0]    index,
  output logic                       mem_we,
  output logic        [AW-1:0]       mem_waddr,
  output logic        [ENTRY_W-1:0]  mem_wdata,
  output logic                       mem_re,
  output logic        [AW-1:0]       mem_raddr,
  input  logic        [ENTRY_W-1:0]  mem_rdata,
  output logic                       done,
  output logic        [STATUS_W-1:0] status,
  output entry_t                     result,
  output logic        [COUNT_W-1:0]  count
);

  localparam int SW = ((CW > IDX_W) ? CW : IDX_W) + 1;

  state_t state, state_next;

  logic        [REQ_W-1:0]   req_q;
  logic        [STAMP_W-1:0] st_q;
  logic        [STAMP_W-1:0] tgt_q;
  logic signed [VAL_W-1:0]   steer_q;
  logic signed [VAL_W-1:0]   spd_q;
  logic        [IDX_W-1:0]   idx_q;

  logic [CW-1:0] fill, fill_next;
  logic [AW-1:0] oldest, oldest_next;
  logic [AW-1:0] scan_slot, scan_slot_next;
  logic [CW-1:0] scan_cnt, scan_cnt_next;
  entry_t        hit;
  logic          have_hit;
  logic          hit_load;
  logic          scan_init;

  entry_t rd_entry;
  logic   full;
  logic   push_ok;
  logic   idx_ok;
  logic   above;
  logic   scan_last;
  logic   do_push;
  logic [VAL_W-1:0] steer_mag;

  logic [SW-1:0] sum_newest, sum_push, sum_idx;
  logic [AW-1:0] newest_slot, push_slot, idx_slot;
  logic [AW-1:0] oldest_inc, scan_inc;

  logic                fin;
  logic                fin_found;
  logic [STATUS_W-1:0] fin_status;
  entry_t              fin_entry;
  logic [SW-1:0]       fill_next_ext;

  assign rd_entry = entry_t'(mem_rdata);
  assign busy     = (state != ST_IDLE);
  assign full     = (fill == CW'(CAPACITY));

  // slot arithmetic: operands stay below twice the capacity
  assign sum_newest  = SW'(oldest) + SW'(fill) - SW'(1);
  assign sum_push    = SW'(oldest) + SW'(fill);
  assign sum_idx     = SW'(oldest) + SW'(idx_q);
  assign newest_slot = AW'((sum_newest >= SW'(CAPACITY)) ? sum_newest - SW'(CAPACITY)
                                                         : sum_newest);
  assign push_slot   = AW'((sum_push >= SW'(CAPACITY)) ? sum_push - SW'(CAPACITY) : sum_push);
  assign idx_slot    = AW'((sum_idx >= SW'(CAPACITY)) ? sum_idx - SW'(CAPACITY) : sum_idx);
  assign oldest_inc  = (oldest == AW'(CAPACITY - 1)) ? '0 : oldest + AW'(1);
  assign scan_inc    = (scan_slot == AW'(CAPACITY - 1)) ? '0 : scan_slot + AW'(1);

  assign steer_mag = steer_q[VAL_W-1] ? (~steer_q + VAL_W'(1)) : steer_q;
  assign push_ok   = (st_q != '0) && !spd_q[VAL_W-1]
                     && (spd_q[LIM_W-1:0] <= limits.max_speed)
                     && (steer_mag <= {1'b0, limits.max_steering});
  assign idx_ok    = (SW'(idx_q) < SW'(fill));
  assign above     = (rd_entry.stamp > st_q);
  assign scan_last = (scan_cnt == fill);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_PUSH:   state_next = (push_ok && fill != '0) ? ST_PUSH_CMP : ST_IDLE;
          REQ_LATEST: state_next = (fill != '0) ? ST_SCAN : ST_IDLE;
          REQ_NEXT:   state_next = (fill != '0 && tgt_q >= st_q) ? ST_SCAN : ST_IDLE;
          REQ_INDEX:  state_next = idx_ok ? ST_IDX_RD : ST_IDLE;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_PUSH_CMP: state_next = ST_IDLE;
      ST_IDX_RD:   state_next = ST_IDLE;
      ST_SCAN: begin
        if (above || scan_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re         = 1'b0;
    mem_raddr      = scan_slot;
    do_push        = 1'b0;
    fin            = 1'b0;
    fin_found      = 1'b0;
    fin_status     = STATUS_NOT_FOUND;
    fin_entry      = rd_entry;
    scan_init      = 1'b0;
    scan_slot_next = scan_slot;
    scan_cnt_next  = scan_cnt;
    hit_load       = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_EXEC: begin
        unique case (req_q)
          REQ_PUSH: begin
            if (!push_ok) begin
              fin        = 1'b1;
              fin_status = STATUS_REJECTED;
            end else if (fill == '0) begin
              do_push    = 1'b1;
              fin        = 1'b1;
              fin_status = STATUS_OK;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = newest_slot;
            end
          end
          REQ_CLEAR: begin
            fin        = 1'b1;
            fin_status = STATUS_OK;
          end
          REQ_LATEST, REQ_NEXT: begin
            if (fill == '0 || (req_q == REQ_NEXT && tgt_q < st_q)) begin
              fin = 1'b1;
            end else begin
              mem_re         = 1'b1;
              mem_raddr      = oldest;
              scan_init      = 1'b1;
              scan_slot_next = oldest_inc;
              scan_cnt_next  = CW'(1);
            end
          end
          REQ_INDEX: begin
            if (idx_ok) begin
              mem_re    = 1'b1;
              mem_raddr = idx_slot;
            end else begin
              fin = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
      end
      ST_PUSH_CMP: begin
        fin = 1'b1;
        if (st_q > rd_entry.stamp) begin
          do_push    = 1'b1;
          fin_status = STATUS_OK;
        end else begin
          fin_status = STATUS_REJECTED;
        end
      end
      ST_IDX_RD: begin
        fin        = 1'b1;
        fin_found  = 1'b1;
        fin_status = STATUS_OK;
      end
      ST_SCAN: begin
        if (above) begin
          fin = 1'b1;
          if (req_q == REQ_LATEST) begin
            fin_found = have_hit;
            fin_entry = hit;
          end else begin
            fin_found = (rd_entry.stamp <= tgt_q);
          end
        end else if (scan_last) begin
          fin       = 1'b1;
          fin_found = (req_q == REQ_LATEST);
        end else begin
          hit_load       = 1'b1;
          mem_re         = 1'b1;
          mem_raddr      = scan_slot;
          scan_slot_next = scan_inc;
          scan_cnt_next  = scan_cnt + CW'(1);
        end
        if (fin) fin_status = fin_found ? STATUS_OK : STATUS_NOT_FOUND;
      end
      default: ;
    endcase
  end

  // ring pointers: clear resets both, a push appends or overwrites the oldest
  always_comb begin
    fill_next   = fill;
    oldest_next = oldest;
    if (state == ST_EXEC && req_q == REQ_CLEAR) begin
      fill_next   = '0;
      oldest_next = '0;
    end else if (do_push) begin
      if (full) oldest_next = oldest_inc;
      else      fill_next   = fill + CW'(1);
    end
  end

  assign mem_we        = do_push;
  assign mem_waddr     = full ? oldest : push_slot;
  assign mem_wdata     = ENTRY_W'({st_q, steer_q, spd_q});
  assign fill_next_ext = SW'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      fill   <= '0;
      oldest <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      oldest <= oldest_next;
      done   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_q   <= req_type;
      st_q    <= stamp;
      tgt_q   <= target_stamp;
      steer_q <= steering;
      spd_q   <= speed;
      idx_q   <= index;
    end
    scan_slot <= scan_slot_next;
    scan_cnt  <= scan_cnt_next;
    if (scan_init) have_hit <= 1'b0;
    else if (hit_load) have_hit <= 1'b1;
    if (hit_load) hit <= rd_entry;
    if (fin) begin
      status <= fin_status;
      result <= fin_found ? fin_entry : '0;
      count  <= fill_next_ext[COUNT_W-1:0];
    end
  end

endmodule

[design/timestamped_command_history.sv]
// Sequence, start accepted to done: clear, an unknown request, a push onto an
//   empty ring or one failing the value checks, and a not-found answer that needs no read
//   finish in the execute state; other pushes and read by index add a memory read and a compare or read-back state;
//   a stamp query walks from the oldest entry, one entry read per cycle from the single-read-port memory.
// Requests: the next request is taken in the cycle done is high, so requests never overlap.
//   The receiver cannot stall. Reset (rst, sync): empty ring, idle, default limits.
module timestamped_command_history
  import thc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic        [REQ_W-1:0]    req_type,
  input  logic        [STAMP_W-1:0]  stamp,
  input  logic        [STAMP_W-1:0]  target_stamp,
  input  logic signed [VAL_W-1:0]    steering,
  input  logic signed [VAL_W-1:0]    speed,
  input  logic        [IDX_W-1:0]    index,
  input  logic                       cfg_we,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [LIM_W-1:0]    cfg_data,
  output logic                       done,
  output logic        [STATUS_W-1:0] status,
  output logic        [STAMP_W-1:0]  found_stamp,
  output logic signed [VAL_W-1:0]    found_steering,
  output logic signed [VAL_W-1:0]    found_speed,
  output logic        [COUNT_W-1:0]  count
);

  localparam int AW = $clog2(CAPACITY);

  limits_t limits;

  // Memory side: one write and one registered read per cycle. The sequencer only
  // reads after its own write has landed, so no forwarding path is needed: busy
  // holds off every new request until the previous one has finished.
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;
  entry_t             result;

  // Limit registers; the user writes them only while idle, and the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.max_speed    <= MAX_SPEED_RST;
      limits.max_steering <= MAX_STEERING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SPEED:    limits.max_speed    <= cfg_data;
        CFG_MAX_STEERING: limits.max_steering <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: checks and appends pushes, clears, reads by index, walks the ring oldest first
  // for stamp queries, and holds the result registers that drive the outputs.
  thc_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .limits       (limits),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .stamp        (stamp),
    .target_stamp (target_stamp),
    .steering     (steering),
    .speed        (speed),
    .index        (index),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .done         (done),
    .status       (status),
    .result       (result),
    .count        (count)
  );

  // Entry store: stamp, steering and speed side by side in one word.
  thc_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(ENTRY_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Drop the entry fields onto the result ports; zero when nothing was found.
  assign found_stamp    = result.stamp;
  assign found_steering = result.steering;
  assign found_speed    = result.speed;

endmodule

[design/thc_checker.sv]
module thc_checker
  import thc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic        [STATUS_W-1:0] status,
  input logic        [STAMP_W-1:0]  found_stamp,
  input logic signed [VAL_W-1:0]    found_steering,
  input logic signed [VAL_W-1:0]    found_speed,
  input logic        [COUNT_W-1:0]  count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STATUS_OK || status == STATUS_REJECTED
              || status == STATUS_NOT_FOUND))
    else $error("bad status code");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (done && status != STATUS_OK) |->
      (found_stamp == '0 && found_steering == '0 && found_speed == '0))
    else $error("entry fields set without a found entry");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (CAPACITY > 63 || int'(count) <= CAPACITY))
    else $error("count beyond capacity");

endmodule

bind timestamped_command_history thc_checker #(.CAPACITY(CAPACITY)) u_thc_checker (.*);

[verif/tb_timestamped_command_history.sv]
module tb_timestamped_command_history;
  import thc_pkg::*;

  localparam int                 CAP         = CAPACITY_DEF;
  localparam int                 CYCLE_LIMIT = 1_000_000;
  // Settling wait after the last answer, sized from the capacity.
  localparam int                 TAIL_CYCLES = CAPACITY_DEF + 16;
  localparam logic [STAMP_W-1:0] STAMP_MAX   = {STAMP_W{1'b1}};
  localparam logic [LIM_W-1:0]   LIM_MAX     = {LIM_W{1'b1}};
  // Codes the block must answer as not found and otherwise ignore.
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN_LO = 3'd5;
  localparam logic [REQ_W-1:0]   REQ_UNKNOWN_HI = 3'd7;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic        [STAMP_W-1:0]  stamp;
    logic signed [VAL_W-1:0]    steering;
    logic signed [VAL_W-1:0]    speed;
    logic        [COUNT_W-1:0]  count;
  } answer_t;

  // Scoreboard: carries its own copy of the ring and the limits, predicts one
  // answer per accepted request and checks answers strictly in order.
  class history_scoreboard;
    entry_t           ring [CAP];
    int unsigned      oldest;
    int unsigned      fill;
    logic [LIM_W-1:0] speed_limit;
    logic [LIM_W-1:0] steer_limit;
    answer_t          pending_answers [$];
    int               failures;

    function new();
      oldest      = 0;
      fill        = 0;
      speed_limit = MAX_SPEED_RST;
      steer_limit = MAX_STEERING_RST;
      failures    = 0;
    endfunction

    function int unsigned slot(int unsigned chrono);
      return (oldest + chrono) % CAP;
    endfunction

    function int unsigned held();
      return fill;
    endfunction

    function logic [STAMP_W-1:0] stamp_at(int unsigned chrono);
      return ring[slot(chrono)].stamp;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
      if (idx == CFG_MAX_SPEED) begin
        speed_limit = data;
      end else begin
        steer_limit = data;
      end
    endfunction

    // Apply the push rules; store the entry and return 1 when it is taken.
    function bit take_push(logic [STAMP_W-1:0] st, logic signed [VAL_W-1:0] steer,
                           logic signed [VAL_W-1:0] spd);
      int     mag;
      int     spd_i;
      entry_t e;
      mag   = steer;
      spd_i = spd;
      if (mag < 0) mag = -mag;
      if (st == '0) return 0;
      if (spd_i < 0 || spd_i > int'(speed_limit)) return 0;
      if (mag > int'(steer_limit)) return 0;
      if (fill > 0 && st <= stamp_at(fill - 1)) return 0;
      e.stamp    = st;
      e.steering = steer;
      e.speed    = spd;
      if (fill < CAP) begin
        ring[slot(fill)] = e;
        fill++;
      end else begin
        // Full ring: overwrite the oldest entry and advance past it.
        ring[oldest] = e;
        oldest       = (oldest + 1) % CAP;
      end
      return 1;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [STAMP_W-1:0] st,
                               logic [STAMP_W-1:0] tgt, logic signed [VAL_W-1:0] steer,
                               logic signed [VAL_W-1:0] spd, logic [IDX_W-1:0] idx);
      answer_t     a;
      entry_t      e;
      entry_t      hit_entry;
      bit          hit;
      int unsigned k;
      a         = '0;
      a.status  = STATUS_NOT_FOUND;
      hit       = 0;
      hit_entry = '0;
      case (req)
        REQ_PUSH: begin
          a.status = take_push(st, steer, spd) ? STATUS_OK : STATUS_REJECTED;
        end
        REQ_CLEAR: begin
          oldest   = 0;
          fill     = 0;
          a.status = STATUS_OK;
        end
        REQ_LATEST: begin
          for (k = 0; k < fill; k++) begin
            e = ring[slot(k)];
            if (e.stamp > st) break;
            hit_entry = e;
            hit       = 1;
          end
        end
        REQ_NEXT: begin
          // A target before the query stamp never finds anything.
          if (tgt >= st) begin
            for (k = 0; k < fill; k++) begin
              e = ring[slot(k)];
              if (e.stamp > st) begin
                if (e.stamp <= tgt) begin
                  hit_entry = e;
                  hit       = 1;
                end
                break;
              end
            end
          end
        end
        REQ_INDEX: begin
          if (idx < fill) begin
            hit_entry = ring[slot(idx)];
            hit       = 1;
          end
        end
        default: ;
      endcase
      if (hit) begin
        a.status   = STATUS_OK;
        a.stamp    = hit_entry.stamp;
        a.steering = hit_entry.steering;
        a.speed    = hit_entry.speed;
      end
      a.count = fill[COUNT_W-1:0];
      pending_answers.push_back(a);
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st_got, logic [STAMP_W-1:0] stamp_got,
                               logic signed [VAL_W-1:0] steer_got,
                               logic signed [VAL_W-1:0] spd_got,
                               logic [COUNT_W-1:0] count_got);
      answer_t a;
      if (pending_answers.size() == 0) begin
        flag($sformatf("answer with no request waiting (status %0d)", st_got));
        return;
      end
      a = pending_answers.pop_front();
      if (st_got !== a.status)
        flag($sformatf("status expected %0d got %0d", a.status, st_got));
      if (stamp_got !== a.stamp)
        flag($sformatf("found_stamp expected %0d got %0d", a.stamp, stamp_got));
      if (steer_got !== a.steering)
        flag($sformatf("found_steering expected %0d got %0d", a.steering, steer_got));
      if (spd_got !== a.speed)
        flag($sformatf("found_speed expected %0d got %0d", a.speed, spd_got));
      if (count_got !== a.count)
        flag($sformatf("count expected %0d got %0d", a.count, count_got));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic        [REQ_W-1:0]    req_type;
  logic        [STAMP_W-1:0]  stamp;
  logic        [STAMP_W-1:0]  target_stamp;
  logic signed [VAL_W-1:0]    steering;
  logic signed [VAL_W-1:0]    speed;
  logic        [IDX_W-1:0]    index;
  logic                       cfg_we;
  logic        [CFG_IDX_W-1:0] cfg_index;
  logic        [LIM_W-1:0]    cfg_data;
  logic                       done;
  logic        [STATUS_W-1:0] status;
  logic        [STAMP_W-1:0]  found_stamp;
  logic signed [VAL_W-1:0]    found_steering;
  logic signed [VAL_W-1:0]    found_speed;
  logic        [COUNT_W-1:0]  count;

  history_scoreboard sb;
  int                n_accepted;
  int                cycles;
  bit                calm;         // no gaps while set
  logic [STAMP_W-1:0] stamp_base;  // base that the first push stamp after a clear steps up from

  timestamped_command_history u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .stamp          (stamp),
    .target_stamp   (target_stamp),
    .steering       (steering),
    .speed          (speed),
    .index          (index),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .status         (status),
    .found_stamp    (found_stamp),
    .found_steering (found_steering),
    .found_speed    (found_speed),
    .count          (count)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Sample at the rising edge: check the answer first, then predict for a
  // request taken at this same edge (the block takes a new request while done
  // is high, and that answer always belongs to an older request).
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(status, found_stamp, found_steering, found_speed, count);
      if (start && !busy) begin
        sb.note_request(req_type, stamp, target_stamp, steering, speed, index);
        n_accepted++;
      end
    end
  end

  // Watchdog: end the run as a mismatch once the cycle limit is passed.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timestamped_command_history: mismatch");
      $finish;
    end
  end

  function automatic logic [STAMP_W-1:0] rand_stamp();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[STAMP_W-1:0];
  endfunction

  // Mostly back-to-back or short gaps, a few long ones.
  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  // Hold the request until the block takes it; leave start high afterwards so
  // a following request can go out back to back.
  task automatic issue(logic [REQ_W-1:0] req, logic [STAMP_W-1:0] st,
                       logic [STAMP_W-1:0] tgt, logic signed [VAL_W-1:0] steer,
                       logic signed [VAL_W-1:0] spd, logic [IDX_W-1:0] idx);
    int gap;
    int seen;
    gap = gap_len();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type     = req;
    stamp        = st;
    target_stamp = tgt;
    steering     = steer;
    speed        = spd;
    index        = idx;
    start        = 1'b1;
    seen         = n_accepted;
    do @(negedge clk); while (n_accepted == seen);
  endtask

  // Drop start, wait for every answer, then let the block settle.
  task automatic drain();
    start = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_limits(logic [LIM_W-1:0] spd_lim, logic [LIM_W-1:0] steer_lim);
    cfg_we    = 1'b1;
    cfg_index = CFG_MAX_SPEED;
    cfg_data  = spd_lim;
    @(negedge clk);
    cfg_index = CFG_MAX_STEERING;
    cfg_data  = steer_lim;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.set_limit(CFG_MAX_SPEED, spd_lim);
    sb.set_limit(CFG_MAX_STEERING, steer_lim);
  endtask

  task automatic push(logic [STAMP_W-1:0] st, int steer, int spd);
    issue(REQ_PUSH, st, rand_stamp(), steer[VAL_W-1:0], spd[VAL_W-1:0], IDX_W'($urandom));
  endtask

  // Extremes of every field, every defined request code, and the corner answers:
  // target before stamp, index past the count, an unknown code.
  task automatic directed_part();
    calm = 1'b0;
    issue(REQ_LATEST, STAMP_MAX, '0, '0, '0, '0);
    issue(REQ_INDEX, '0, '0, '0, '0, '0);
    push('0, 0, 0);
    push(63'd100, int'(MAX_STEERING_RST), int'(MAX_SPEED_RST));
    push(63'd100, 0, 0);
    push(63'd50, 0, 0);
    push(63'd200, 0, -1);
    push(63'd200, 0, int'(MAX_SPEED_RST) + 1);
    push(63'd200, -int'(MAX_STEERING_RST) - 1, 0);
    push(63'd200, int'(MAX_STEERING_RST) + 1, 0);
    push(63'd200, -int'(MAX_STEERING_RST), 0);
    issue(REQ_LATEST, 63'd150, '0, '0, '0, '0);
    issue(REQ_LATEST, 63'd99, '0, '0, '0, '0);
    issue(REQ_LATEST, STAMP_MAX, '0, '0, '0, '0);
    issue(REQ_NEXT, 63'd100, 63'd200, '0, '0, '0);
    issue(REQ_NEXT, 63'd100, 63'd150, '0, '0, '0);
    issue(REQ_NEXT, 63'd200, 63'd100, '0, '0, '0);
    issue(REQ_NEXT, 63'd200, STAMP_MAX, '0, '0, '0);
    issue(REQ_NEXT, '0, STAMP_MAX, '0, '0, '0);
    issue(REQ_INDEX, '0, '0, '0, '0, 5'd1);
    issue(REQ_INDEX, STAMP_MAX, STAMP_MAX, '1, '1, '1);
    issue(REQ_UNKNOWN_HI, STAMP_MAX, STAMP_MAX, '1, '1, '1);
    push(STAMP_MAX, -8388608, 0);
    push(STAMP_MAX, 0, 0);
    issue(REQ_CLEAR, '0, '0, '0, '0, '0);
  endtask

  // Stamp near a held entry, or anywhere when the ring is empty and now and then otherwise.
  function automatic logic [STAMP_W-1:0] query_stamp();
    logic [STAMP_W-1:0] e;
    if (sb.held() == 0 || $urandom_range(0, 9) == 0) begin
      return $urandom_range(0, 1) ? rand_stamp() : STAMP_W'($urandom_range(0, 2000));
    end
    e = sb.stamp_at($urandom_range(0, sb.held() - 1));
    case ($urandom_range(0, 3))
      0: return e;
      1: return (e == '0) ? e : e - 1'b1;
      2: return (e == STAMP_MAX) ? e : e + 1'b1;
      default: return (e > STAMP_MAX - 5000) ? STAMP_MAX : e + $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic int valid_steering();
    int lim;
    lim = int'(sb.steer_limit);
    case ($urandom_range(0, 9))
      0: return lim;
      1: return -lim;
      default: return int'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  function automatic int valid_speed();
    int lim;
    lim = int'(sb.speed_limit);
    case ($urandom_range(0, 9))
      0: return lim;
      1: return 0;
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  task automatic clear_ring();
    // Restart stamps low, anywhere, or close to the top of the range.
    case ($urandom_range(0, 3))
      0, 1: stamp_base = STAMP_W'($urandom_range(0, 100));
      2: stamp_base = rand_stamp();
      default: stamp_base = STAMP_MAX - $urandom_range(0, 200000);
    endcase
    issue(REQ_CLEAR, rand_stamp(), rand_stamp(), VAL_W'($urandom), VAL_W'($urandom),
          IDX_W'($urandom));
  endtask

  task automatic random_request();
    int                 r;
    int                 steer;
    int                 spd;
    logic [63:0]        step;
    logic [63:0]        next_stamp;
    logic [STAMP_W-1:0] newest;
    logic [STAMP_W-1:0] st;
    logic [STAMP_W-1:0] tgt;
    r      = $urandom_range(0, 99);
    newest = (sb.held() > 0) ? sb.stamp_at(sb.held() - 1) : stamp_base;
    case ($urandom_range(0, 9))
      0: step = {32'd0, $urandom} + 1;
      1, 2: step = $urandom_range(1, 1 << 20);
      default: step = $urandom_range(1, 1000);
    endcase
    next_stamp = {1'b0, newest} + step;
    steer      = valid_steering();
    spd        = valid_speed();
    if (r < 45) begin
      // Well-formed push; clear instead when the stamps would run off the top.
      if (next_stamp[STAMP_W]) clear_ring();
      else push(next_stamp[STAMP_W-1:0], steer, spd);
    end else if (r < 55) begin
      st = next_stamp[STAMP_W] ? STAMP_MAX : next_stamp[STAMP_W-1:0];
      case ($urandom_range(0, 5))
        0: push('0, steer, spd);
        1: push((sb.held() > 0) ? newest - $urandom_range(0, 3) : '0, steer, spd);
        2: push(st, steer, -int'($urandom_range(1, 8388608)));
        3: push(st, steer, (sb.speed_limit == LIM_MAX) ? -1 :
                int'($urandom_range(int'(sb.speed_limit) + 1, int'(LIM_MAX))));
        4: begin
          if (sb.steer_limit == LIM_MAX) begin
            push(st, -8388608, spd);
          end else begin
            steer = $urandom_range(int'(sb.steer_limit) + 1, int'(LIM_MAX));
            push(st, $urandom_range(0, 1) ? steer : -steer, spd);
          end
        end
        default: issue(REQ_PUSH, rand_stamp(), rand_stamp(), VAL_W'($urandom),
                       VAL_W'($urandom), IDX_W'($urandom));
      endcase
    end else if (r < 57) begin
      clear_ring();
    end else if (r < 72) begin
      issue(REQ_LATEST, query_stamp(), rand_stamp(), VAL_W'($urandom), VAL_W'($urandom),
            IDX_W'($urandom));
    end else if (r < 85) begin
      st = query_stamp();
      case ($urandom_range(0, 4))
        0: tgt = rand_stamp();
        1: tgt = (st == '0) ? st : st - $urandom_range(1, 100);
        2: tgt = st;
        default: tgt = query_stamp();
      endcase
      issue(REQ_NEXT, st, tgt, VAL_W'($urandom), VAL_W'($urandom), IDX_W'($urandom));
    end else if (r < 95) begin
      issue(REQ_INDEX, rand_stamp(), rand_stamp(), VAL_W'($urandom), VAL_W'($urandom),
            ($urandom_range(0, 4) != 0 && sb.held() > 0) ?
              IDX_W'($urandom_range(0, sb.held() - 1)) : IDX_W'($urandom));
    end else begin
      issue(REQ_UNKNOWN_LO + REQ_W'($urandom_range(0, REQ_UNKNOWN_HI - REQ_UNKNOWN_LO)),
            rand_stamp(), rand_stamp(), VAL_W'($urandom), VAL_W'($urandom),
            IDX_W'($urandom));
    end
  endtask

  task automatic random_part(int n_items);
    int n;
    for (n = 0; n < n_items; n++) begin
      // Run a stretch of each hundred requests with no gaps at all.
      calm = (n % 100) >= 60 && (n % 100) < 85;
      random_request();
    end
    calm = 1'b0;
  endtask

  initial begin
    sb           = new();
    n_accepted   = 0;
    cycles       = 0;
    calm         = 1'b0;
    stamp_base   = STAMP_W'(1);
    rst          = 1'b1;
    start        = 1'b0;
    req_type     = REQ_PUSH;
    stamp        = '0;
    target_stamp = '0;
    steering     = '0;
    speed        = '0;
    index        = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_MAX_SPEED;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_part();
    drain();
    write_limits(LIM_MAX, LIM_MAX);
    random_part(250);
    drain();
    write_limits('0, '0);
    random_part(100);
    drain();
    write_limits(LIM_W'($urandom_range(0, int'(LIM_MAX))),
                 LIM_W'($urandom_range(0, int'(LIM_MAX))));
    random_part(200);
    drain();
    write_limits(MAX_SPEED_RST, MAX_STEERING_RST);
    random_part(250);
    drain();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("timestamped_command_history: match");
    end else begin
      $display("timestamped_command_history: mismatch");
    end
    $finish;
  end

endmodule

[timestamped_command_history.f]
design/thc_pkg.sv
design/thc_mem.sv
design/thc_ctrl.sv
design/timestamped_command_history.sv
design/thc_checker.sv
verif/tb_timestamped_command_history.sv
